// File: rtl/kvbrd_pkg.sv
// ----------------------------------------------------------------------------
// kvbrd_pkg
// Shared types and constants of the key/value block record deframer.
// ----------------------------------------------------------------------------
package kvbrd_pkg;

	localparam logic [1:0] KIND_HEADER = 2'd0;
	localparam logic [1:0] KIND_KEY    = 2'd1;
	localparam logic [1:0] KIND_VALUE  = 2'd2;
	localparam logic [1:0] KIND_STATUS = 2'd3;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_CRC      = 3'd1;
	localparam logic [2:0] ST_TRUNC    = 3'd2;
	localparam logic [2:0] ST_TRAILING = 3'd3;
	localparam logic [2:0] ST_EMPTY    = 3'd4;

	localparam int RES_W = 2 + 8 + 64 + 8 + 16 + 16 + 12 + 3;

	// One result item as it travels from the parser to the output queue.
	typedef struct packed {
		logic [2:0]  block_status;
		logic [11:0] record_number;
		logic [15:0] val_len;
		logic [15:0] key_len;
		logic [7:0]  operation_code;
		logic [63:0] sequence_number;
		logic [7:0]  payload_byte;
		logic [1:0]  kind;
	} result_t;

	function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
		logic [31:0] c;
		c = c_in ^ {24'd0, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ 32'hEDB88320) : (c >> 1);
		end
		return c;
	endfunction

endpackage

// File: rtl/kvbrd_parser.sv
// ----------------------------------------------------------------------------
// kvbrd_parser
// Front part: takes block bytes, runs the CRC and the record parser, and
// produces at most one result per byte.
// ----------------------------------------------------------------------------
module kvbrd_parser #(
	parameter int MAX_BLOCK_BYTES = 65536
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [7:0]          in_byte,
	input  logic                in_last,
	output logic                res_valid,
	output kvbrd_pkg::result_t  res
);

	localparam int LW = $clog2(MAX_BLOCK_BYTES);
	localparam logic [32:0] LIM = 33'(MAX_BLOCK_BYTES - 1);

	typedef enum logic [2:0] {
		PH_COUNT, PH_HEADER, PH_KEY, PH_VALUE, PH_DONE, PH_EMPTY
	} phase_t;

	phase_t      phase_q;
	logic [7:0]  dl_q [4];
	logic [2:0]  fill_q;
	logic [31:0] crc_q;
	logic [4:0]  cnt_q;
	logic [31:0] acc_q;
	logic [31:0] rexp_q;
	logic [11:0] rdone_q;
	logic [LW-1:0] klen_q;
	logic [LW-1:0] vlen_q;
	logic [63:0] seq_q;
	logic [7:0]  op_q;

	logic [31:0] acc_n;
	logic [LW-1:0] sat_n;
	logic [3:0]  t_n;
	logic [31:0] stored;
	logic [2:0]  st_n;
	logic        fin_n;
	logic [2:0]  fill_n;
	logic [31:0] crc_n;

	phase_t      phase_d;
	logic [7:0]  dl_d [4];
	logic [2:0]  fill_d;
	logic [31:0] crc_d;
	logic [4:0]  cnt_d;
	logic [31:0] acc_d;
	logic [31:0] rexp_d;
	logic [11:0] rdone_d;
	logic [LW-1:0] klen_d;
	logic [LW-1:0] vlen_d;
	logic [63:0] seq_d;
	logic [7:0]  op_d;
	logic        res_valid_d;
	kvbrd_pkg::result_t res_d;

	function automatic logic [15:0] out_len(input logic [LW-1:0] v);
		logic [32:0] w;
		w = 33'(v);
		return (w > 33'hFFFF) ? 16'hFFFF : w[15:0];
	endfunction

	always_comb begin
		acc_n = acc_q | ({24'd0, in_byte} << {cnt_q[1:0] - ((phase_q == PH_HEADER) ?
			2'd1 : 2'd0), 3'd0});
		sat_n = ({1'b0, acc_n} > LIM) ? LIM[LW-1:0] : acc_n[LW-1:0];
		crc_n = (fill_q[2]) ? kvbrd_pkg::crc_byte(crc_q, dl_q[0]) : crc_q;
		fill_n = fill_q[2] ? 3'd4 : fill_q + 3'd1;
		t_n = cnt_q[3:0];
		if ((phase_q == PH_DONE || phase_q == PH_EMPTY) && cnt_q < 5'd5) begin
			t_n = cnt_q[3:0] + 4'd1;
		end
		fin_n = (phase_q == PH_DONE || phase_q == PH_EMPTY);
		if (fill_q[2]) begin
			stored = {in_byte, dl_q[3], dl_q[2], dl_q[1]};
		end else begin
			stored = {in_byte, dl_q[2], dl_q[1], dl_q[0]};
		end
		if (!fin_n || t_n < 4'd4 || fill_n < 3'd4) begin
			st_n = kvbrd_pkg::ST_TRUNC;
		end else if (stored != ~crc_n) begin
			st_n = kvbrd_pkg::ST_CRC;
		end else if (phase_q == PH_EMPTY) begin
			st_n = kvbrd_pkg::ST_EMPTY;
		end else if (t_n > 4'd4) begin
			st_n = kvbrd_pkg::ST_TRAILING;
		end else begin
			st_n = kvbrd_pkg::ST_OK;
		end
	end

	always_comb begin
		phase_d = phase_q;
		dl_d = dl_q;
		fill_d = fill_q;
		crc_d = crc_q;
		cnt_d = cnt_q;
		acc_d = acc_q;
		rexp_d = rexp_q;
		rdone_d = rdone_q;
		klen_d = klen_q;
		vlen_d = vlen_q;
		seq_d = seq_q;
		op_d = op_q;
		res_valid_d = 1'b0;
		res_d = res;
		if (in_valid) begin
			res_d = '0;
			crc_d = crc_n;
			fill_d = fill_n;
			if (fill_q[2]) begin
				dl_d[0] = dl_q[1];
				dl_d[1] = dl_q[2];
				dl_d[2] = dl_q[3];
				dl_d[3] = in_byte;
			end else begin
				dl_d[fill_q[1:0]] = in_byte;
			end
			unique case (phase_q)
				PH_COUNT: begin
					if (cnt_q >= 5'd3) begin
						rexp_d = acc_n;
						acc_d = '0;
						cnt_d = '0;
						phase_d = (acc_n != 0) ? PH_HEADER : PH_EMPTY;
					end else begin
						acc_d = acc_n;
						cnt_d = cnt_q + 5'd1;
					end
				end
				PH_HEADER: begin
					if (cnt_q < 5'd8) begin
						if (cnt_q == 5'd0) begin
							seq_d = {56'd0, in_byte};
							acc_d = '0;
						end else begin
							seq_d[{cnt_q[2:0], 3'd0} +: 8] = in_byte;
						end
					end else if (cnt_q == 5'd8) begin
						op_d = in_byte;
					end else if (cnt_q == 5'd12) begin
						klen_d = sat_n;
						acc_d = '0;
					end else begin
						acc_d = acc_n;
					end
					if (cnt_q < 5'd16) begin
						cnt_d = cnt_q + 5'd1;
					end else begin
						vlen_d = sat_n;
						acc_d = '0;
						res_valid_d = 1'b1;
						res_d.kind = kvbrd_pkg::KIND_HEADER;
						res_d.sequence_number = seq_q;
						res_d.operation_code = op_q;
						res_d.key_len = out_len(klen_q);
						res_d.val_len = out_len(sat_n);
						res_d.record_number = rdone_q;
						rdone_d = rdone_q + 12'd1;
						rexp_d = rexp_q - 32'd1;
						cnt_d = '0;
						if (klen_q != '0) phase_d = PH_KEY;
						else if (sat_n != '0) phase_d = PH_VALUE;
						else phase_d = (rexp_q != 32'd1) ? PH_HEADER : PH_DONE;
					end
				end
				PH_KEY: begin
					res_valid_d = 1'b1;
					res_d.kind = kvbrd_pkg::KIND_KEY;
					res_d.payload_byte = in_byte;
					res_d.record_number = rdone_q - 12'd1;
					klen_d = klen_q - LW'(1);
					if (klen_q == LW'(1)) begin
						if (vlen_q != '0) phase_d = PH_VALUE;
						else phase_d = (rexp_q != 0) ? PH_HEADER : PH_DONE;
					end
				end
				PH_VALUE: begin
					res_valid_d = 1'b1;
					res_d.kind = kvbrd_pkg::KIND_VALUE;
					res_d.payload_byte = in_byte;
					res_d.record_number = rdone_q - 12'd1;
					vlen_d = vlen_q - LW'(1);
					if (vlen_q == LW'(1)) begin
						phase_d = (rexp_q != 0) ? PH_HEADER : PH_DONE;
					end
				end
				default: begin
					cnt_d = {1'b0, t_n};
				end
			endcase
			if (in_last) begin
				res_valid_d = 1'b1;
				res_d = '0;
				res_d.kind = kvbrd_pkg::KIND_STATUS;
				res_d.block_status = st_n;
				phase_d = PH_COUNT;
				dl_d = '{default: '0};
				fill_d = '0;
				crc_d = '1;
				cnt_d = '0;
				acc_d = '0;
				rexp_d = '0;
				rdone_d = '0;
				klen_d = '0;
				vlen_d = '0;
				seq_d = '0;
				op_d = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_COUNT;
			fill_q <= '0;
			crc_q <= '1;
			cnt_q <= '0;
			acc_q <= '0;
			rexp_q <= '0;
			rdone_q <= '0;
			klen_q <= '0;
			vlen_q <= '0;
			seq_q <= '0;
			op_q <= '0;
			res_valid <= 1'b0;
			res <= '0;
			dl_q <= '{default: '0};
		end else begin
			phase_q <= phase_d;
			fill_q <= fill_d;
			crc_q <= crc_d;
			cnt_q <= cnt_d;
			acc_q <= acc_d;
			rexp_q <= rexp_d;
			rdone_q <= rdone_d;
			klen_q <= klen_d;
			vlen_q <= vlen_d;
			seq_q <= seq_d;
			op_q <= op_d;
			res_valid <= res_valid_d;
			res <= res_d;
			dl_q <= dl_d;
		end
	end

endmodule

// File: rtl/kvbrd_queue.sv
// ----------------------------------------------------------------------------
// kvbrd_queue
// Back part: a four-entry queue that holds results until the sink takes them.
// ----------------------------------------------------------------------------
module kvbrd_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_valid,
	input  kvbrd_pkg::result_t  wr_data,
	output logic                almost_full,
	output logic                rd_valid,
	input  logic                rd_ready,
	output kvbrd_pkg::result_t  rd_data
);

	kvbrd_pkg::result_t mem_q [4];
	logic [1:0] wp_q;
	logic [1:0] rp_q;
	logic [2:0] cnt_q;
	logic       pop;

	assign pop = rd_valid && rd_ready;
	assign rd_valid = (cnt_q != 3'd0);
	assign rd_data = mem_q[rp_q];
	// The parser's output register may still hold one result and one more byte
	// can be taken in the same cycle, so holding off at two leaves room to spare.
	assign almost_full = (cnt_q >= 3'd2);

	always_ff @(posedge clk) begin
		if (wr_valid) mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_valid) wp_q <= wp_q + 2'd1;
			if (pop) rp_q <= rp_q + 2'd1;
			cnt_q <= cnt_q + {2'd0, wr_valid} - {2'd0, pop};
		end
	end

endmodule

// File: rtl/kv_block_record_deframer_unit.sv
// ----------------------------------------------------------------------------
// kv_block_record_deframer_unit
// Data block parser with CRC-32 check, one byte per transfer.
// ----------------------------------------------------------------------------
// The block takes one byte per cycle while s_tready is high and gives at most
// one result per byte: a header per record, one result per key or value byte,
// and a status on the last byte. A result passes the parser's output register
// and a queue entry before it can leave on the output. The input stalls only
// when the four-entry output queue holds two or more results. Key and value
// results come before the CRC verdict and must be dropped on a bad status.
module kv_block_record_deframer_unit #(
	parameter int MAX_BLOCK_BYTES = 65536
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,  // data_byte
	input  logic         s_tlast,  // data_last
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [127:0] m_tdata,  // payload_byte, sequence_number, operation_code,
	                               // key_len, val_len, record_number,
	                               // block_status, zero fill
	output logic [1:0]   m_tuser   // kind
);

	logic               afull;
	logic               res_valid;
	kvbrd_pkg::result_t res;
	kvbrd_pkg::result_t q_out;

	assign s_tready = !afull;

	kvbrd_parser #(.MAX_BLOCK_BYTES(MAX_BLOCK_BYTES)) u_parser (
		.clk(clk), .arst_n(arst_n), .in_valid(s_tvalid && s_tready),
		.in_byte(s_tdata), .in_last(s_tlast), .res_valid(res_valid), .res(res)
	);

	kvbrd_queue u_queue (
		.clk(clk), .arst_n(arst_n), .wr_valid(res_valid), .wr_data(res),
		.almost_full(afull), .rd_valid(m_tvalid), .rd_ready(m_tready),
		.rd_data(q_out)
	);

	assign m_tuser = q_out.kind;
	assign m_tdata = {1'b0, q_out[kvbrd_pkg::RES_W-1:2]};

endmodule

// File: tb/kv_block_record_deframer_unit_test.sv
// ----------------------------------------------------------------------------
// kv_block_record_deframer_unit_test
// Self-checking bench for the key/value data block parser.
// ----------------------------------------------------------------------------
// Blocks of bytes stream in on the slave side under random idling and a long
// receiver hold-off. A behavioral parser with its own CRC-32 predicts every
// header, key, value and status result, and each output transfer is compared
// field by field with the oldest prediction.
module kv_block_record_deframer_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int BLOCK_LIMIT = 65536;
	localparam int CYCLE_LIMIT = 400000;

	typedef enum logic [2:0] {
		P_COUNT, P_HEADER, P_KEY, P_VALUE, P_DONE, P_EMPTY
	} phase_t;

	typedef struct {
		logic [7:0] data;
		logic       last;
	} byte_in_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [7:0]   s_tdata;
	logic         s_tlast;
	logic         m_tvalid;
	logic         m_tready;
	logic [127:0] m_tdata;
	logic [1:0]   m_tuser;

	kv_block_record_deframer_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	// Parser state of the predictor.
	logic [7:0]  dly [4];
	int          dly_fill;
	logic [31:0] crc_acc;
	phase_t      phase;
	int unsigned fcount;
	logic [63:0] facc;
	logic [31:0] recs_left;
	logic [11:0] recs_done;
	logic [31:0] key_left;
	logic [31:0] val_left;
	logic [63:0] seq_hold;
	logic [7:0]  op_hold;

	kvbrd_pkg::result_t expected_results [$];
	byte_in_t byte_queue [$];
	int       errors;
	int       cycles;
	int       idle_in_pct;
	int       idle_out_pct;
	bit       hold_off;
	int       n_blocks;
	int       n_status;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic logic [31:0] crc_step(logic [31:0] c_in, logic [7:0] b);
		logic [31:0] c;
		c = c_in ^ {24'd0, b};
		for (int i = 0; i < 8; i++)
			c = c[0] ? ((c >> 1) ^ 32'hEDB88320) : (c >> 1);
		return c;
	endfunction

	function automatic logic [31:0] clamp_len(logic [63:0] v);
		return (v > 64'(BLOCK_LIMIT - 1)) ? 32'(BLOCK_LIMIT - 1) : v[31:0];
	endfunction

	function automatic logic [15:0] report_len(logic [31:0] v);
		return (v > 32'hFFFF) ? 16'hFFFF : v[15:0];
	endfunction

	task automatic parser_clear();
		for (int i = 0; i < 4; i++)
			dly[i] = 8'd0;
		dly_fill = 0;
		crc_acc = 32'hFFFFFFFF;
		phase = P_COUNT;
		fcount = 0;
		facc = '0;
		recs_left = '0;
		recs_done = '0;
		key_left = '0;
		val_left = '0;
		seq_hold = '0;
		op_hold = '0;
	endtask

	task automatic record_end();
		fcount = 0;
		phase = (recs_left != 0) ? P_HEADER : P_DONE;
	endtask

	task automatic key_end();
		if (val_left > 0)
			phase = P_VALUE;
		else
			record_end();
	endtask

	function automatic logic [2:0] block_verdict();
		logic [31:0] stored;
		if (!(phase == P_DONE || phase == P_EMPTY) || fcount < 4 || dly_fill < 4)
			return kvbrd_pkg::ST_TRUNC;
		stored = {dly[3], dly[2], dly[1], dly[0]};
		if (stored != ~crc_acc)
			return kvbrd_pkg::ST_CRC;
		if (phase == P_EMPTY)
			return kvbrd_pkg::ST_EMPTY;
		if (fcount > 4)
			return kvbrd_pkg::ST_TRAILING;
		return kvbrd_pkg::ST_OK;
	endfunction

	// Advances the predictor by one byte; returns 1 and the result when one is due.
	task automatic parse_byte(input logic [7:0] b, input logic last, output bit got,
			output kvbrd_pkg::result_t r);
		int unsigned c;
		c = fcount;
		got = 1'b0;
		r = '0;
		if (dly_fill >= 4) begin
			crc_acc = crc_step(crc_acc, dly[0]);
			dly[0] = dly[1];
			dly[1] = dly[2];
			dly[2] = dly[3];
			dly[3] = b;
		end else begin
			dly[dly_fill] = b;
			dly_fill++;
		end
		case (phase)
			P_COUNT: begin
				facc |= 64'(b) << (8 * (c & 3));
				if (c >= 3) begin
					recs_left = facc[31:0];
					facc = '0;
					fcount = 0;
					phase = (recs_left != 0) ? P_HEADER : P_EMPTY;
				end else begin
					fcount = c + 1;
				end
			end
			P_HEADER: begin
				if (c < 8) begin
					if (c == 0) begin
						seq_hold = '0;
						facc = '0;
					end
					seq_hold |= 64'(b) << (8 * c);
				end else if (c == 8) begin
					op_hold = b;
				end else if (c <= 12) begin
					facc |= 64'(b) << (8 * (c - 9));
					if (c == 12) begin
						key_left = clamp_len(facc);
						facc = '0;
					end
				end else begin
					facc |= 64'(b) << (8 * ((c - 13) & 3));
				end
				if (c < 16) begin
					fcount = c + 1;
				end else begin
					val_left = clamp_len(facc);
					facc = '0;
					got = 1'b1;
					r.kind = kvbrd_pkg::KIND_HEADER;
					r.sequence_number = seq_hold;
					r.operation_code = op_hold;
					r.key_len = report_len(key_left);
					r.val_len = report_len(val_left);
					r.record_number = recs_done;
					recs_done++;
					recs_left--;
					if (key_left > 0) begin
						fcount = 0;
						phase = P_KEY;
					end else begin
						key_end();
					end
				end
			end
			P_KEY: begin
				got = 1'b1;
				r.kind = kvbrd_pkg::KIND_KEY;
				r.payload_byte = b;
				r.record_number = recs_done - 12'd1;
				if (key_left > 0)
					key_left--;
				if (key_left == 0)
					key_end();
			end
			P_VALUE: begin
				got = 1'b1;
				r.kind = kvbrd_pkg::KIND_VALUE;
				r.payload_byte = b;
				r.record_number = recs_done - 12'd1;
				if (val_left > 0)
					val_left--;
				if (val_left == 0)
					record_end();
			end
			default: begin
				if (c < 5)
					fcount = c + 1;
			end
		endcase
		if (last) begin
			r = '0;
			r.kind = kvbrd_pkg::KIND_STATUS;
			r.block_status = block_verdict();
			got = 1'b1;
			parser_clear();
		end
	endtask

	// Block assembly helpers: bytes go to byte_queue in order.
	task automatic push_le(input logic [63:0] v, input int n);
		byte_in_t e;
		for (int i = 0; i < n; i++) begin
			e.data = v[8 * i +: 8];
			e.last = 1'b0;
			byte_queue.insert(byte_queue.size(), e);
		end
	endtask

	// Builds one block of recs records; the trailer is a correct CRC unless
	// corrupted, extra bytes may follow the records, or the block may be cut short.
	task automatic build_block(input int recs, input logic [31:0] count_field,
			input int max_len, input bit bad_crc, input int extra, input int cut);
		logic [31:0] crc;
		int          kl;
		int          vl;
		int          start;
		start = byte_queue.size();
		push_le(64'(count_field), 4);
		for (int r = 0; r < recs; r++) begin
			kl = $urandom_range(0, max_len);
			vl = $urandom_range(0, max_len);
			push_le({$urandom, $urandom}, 8);
			push_le(64'($urandom_range(0, 255)), 1);
			push_le(64'(kl), 4);
			push_le(64'(vl), 4);
			for (int i = 0; i < kl + vl; i++)
				push_le(64'($urandom_range(0, 255)), 1);
		end
		for (int i = 0; i < extra; i++)
			push_le(64'($urandom_range(0, 255)), 1);
		crc = 32'hFFFFFFFF;
		for (int i = start; i < byte_queue.size(); i++)
			crc = crc_step(crc, byte_queue[i].data);
		crc = ~crc;
		if (bad_crc)
			crc ^= 32'h1 << $urandom_range(0, 31);
		push_le(64'(crc), 4);
		while (cut > 0 && byte_queue.size() > start + 1) begin
			void'(byte_queue.pop_back());
			cut--;
		end
		byte_queue[byte_queue.size() - 1].last = 1'b1;
		n_blocks++;
	endtask

	task automatic send_bytes();
		bit      got;
		kvbrd_pkg::result_t r;
		byte_in_t e;
		while (byte_queue.size() > 0) begin
			e = byte_queue.pop_front();
			if ($urandom_range(0, 99) < idle_in_pct) begin
				s_tvalid <= 1'b0;
				do @(posedge clk); while ($urandom_range(0, 99) < idle_in_pct);
			end
			s_tvalid <= 1'b1;
			s_tdata <= e.data;
			s_tlast <= e.last;
			do @(posedge clk); while (!s_tready);
			parse_byte(e.data, e.last, got, r);
			if (got)
				expected_results.insert(expected_results.size(), r);
		end
	endtask

	// Directed table: each row is a whole block with, where it is obvious,
	// the status it must end with.
	typedef struct {
		logic [7:0] bytes [$];
		logic [2:0] status;
		bit         known;
	} dir_row_t;

	task automatic run_directed();
		dir_row_t rows [$];
		dir_row_t row;
		byte_in_t e;
		// Single byte block: too short.
		row.bytes = '{8'hFF}; row.status = kvbrd_pkg::ST_TRUNC; row.known = 1'b1;
		rows.insert(rows.size(), row);
		// Count only, no CRC: too short.
		row.bytes = '{8'h00, 8'h00, 8'h00, 8'h00}; row.status = kvbrd_pkg::ST_TRUNC;
		rows.insert(rows.size(), row);
		// Zero records with correct CRC of four zero bytes.
		row.bytes = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h1C, 8'hDF, 8'h44, 8'h21};
		row.status = kvbrd_pkg::ST_EMPTY; rows.insert(rows.size(), row);
		// Zero records, wrong CRC.
		row.bytes = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
		row.status = kvbrd_pkg::ST_CRC; rows.insert(rows.size(), row);
		// Huge record count: parse never finishes.
		row.bytes = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00};
		row.status = kvbrd_pkg::ST_TRUNC; rows.insert(rows.size(), row);
		// One record, all-ones header with saturating lengths, cut mid key.
		row.bytes = '{8'h01, 8'h00, 8'h00, 8'h00};
		for (int i = 0; i < 17; i++)
			row.bytes.insert(row.bytes.size(), 8'hFF);
		for (int i = 0; i < 3; i++)
			row.bytes.insert(row.bytes.size(), 8'hA5);
		row.status = kvbrd_pkg::ST_TRUNC; rows.insert(rows.size(), row);
		foreach (rows[k]) begin
			for (int i = 0; i < rows[k].bytes.size(); i++) begin
				e.data = rows[k].bytes[i];
				e.last = (i == rows[k].bytes.size() - 1);
				byte_queue.insert(byte_queue.size(), e);
			end
			send_bytes();
			if (rows[k].known && expected_results[$].block_status != rows[k].status) begin
				$error("directed row %0d: block_status expected %0d, predicted %0d",
					k, rows[k].status, expected_results[$].block_status);
				errors++;
			end
			n_blocks++;
		end
		// Built blocks: ok with empty key/value, trailing bytes, bad CRC, record count too high.
		build_block(1, 1, 0, 1'b0, 0, 0);
		build_block(2, 2, 3, 1'b0, 2, 0);
		build_block(1, 1, 2, 1'b1, 0, 0);
		build_block(1, 2, 2, 1'b0, 0, 0);
		send_bytes();
	endtask

	task automatic run_random(input int n_bytes);
		int sent;
		int sel;
		int recs;
		sent = 0;
		while (sent < n_bytes) begin
			sel = $urandom_range(0, 99);
			recs = $urandom_range(0, 3);
			if (sel < 60)
				build_block(recs, recs, 6, 1'b0, 0, 0);
			else if (sel < 70)
				build_block(recs, recs, 6, 1'b1, 0, 0);
			else if (sel < 78)
				build_block(recs, recs, 6, 1'b0, $urandom_range(1, 3), 0);
			else if (sel < 88)
				build_block(recs, recs, 6, 1'b0, 0, $urandom_range(1, 10));
			else if (sel < 94)
				build_block(recs, recs + $urandom_range(1, 2), 6, 1'b0, 0, 0);
			else
				build_block(0, $urandom, 0, 1'($urandom_range(0, 1)),
					$urandom_range(0, 6), $urandom_range(0, 6));
			sent += byte_queue.size();
			send_bytes();
		end
	endtask

	task automatic check_field(input string name, input logic [63:0] exp_v,
			input logic [63:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s mismatch: expected %0h, actual %0h", name, exp_v, act_v);
			errors++;
		end
	endtask

	// Receiver: random stall, plus a long hold-off on request.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= !hold_off && ($urandom_range(0, 99) >= idle_out_pct);
		end
	end

	always @(posedge clk) begin
		kvbrd_pkg::result_t r;
		kvbrd_pkg::result_t a;
		cycles <= cycles + 1;
		if (arst_n && m_tvalid && m_tready) begin
			a = '0;
			a.kind = m_tuser;
			a.payload_byte = m_tdata[7:0];
			a.sequence_number = m_tdata[71:8];
			a.operation_code = m_tdata[79:72];
			a.key_len = m_tdata[95:80];
			a.val_len = m_tdata[111:96];
			a.record_number = m_tdata[123:112];
			a.block_status = m_tdata[126:124];
			if (expected_results.size() == 0) begin
				$error("unexpected result transfer, kind %0d", a.kind);
				errors++;
			end else begin
				r = expected_results.pop_front();
				check_field("kind", 64'(r.kind), 64'(a.kind));
				check_field("payload_byte", 64'(r.payload_byte), 64'(a.payload_byte));
				check_field("sequence_number", r.sequence_number, a.sequence_number);
				check_field("operation_code", 64'(r.operation_code),
					64'(a.operation_code));
				check_field("key_len", 64'(r.key_len), 64'(a.key_len));
				check_field("val_len", 64'(r.val_len), 64'(a.val_len));
				check_field("record_number", 64'(r.record_number), 64'(a.record_number));
				check_field("block_status", 64'(r.block_status), 64'(a.block_status));
				if (a.kind == kvbrd_pkg::KIND_STATUS)
					n_status++;
			end
		end
		if (cycles > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		int stall;
		errors = 0;
		cycles = 0;
		n_blocks = 0;
		n_status = 0;
		hold_off = 1'b0;
		idle_in_pct = 28;
		idle_out_pct = 51;
		s_tvalid = 1'b0;
		s_tdata = 8'd0;
		s_tlast = 1'b0;
		arst_n = 1'b0;
		parser_clear();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		run_random(100);
		idle_in_pct = 51;
		idle_out_pct = 28;
		fork
			run_random(100);
			begin
				@(posedge clk);
				hold_off = 1'b1;
				stall = 0;
				while (stall < 200) begin
					@(posedge clk);
					stall++;
				end
				hold_off = 1'b0;
			end
		join
		idle_in_pct = 0;
		idle_out_pct = 0;
		run_random(100);
		s_tvalid <= 1'b0;
		while (expected_results.size() > 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		$display("Covered %0d blocks, %0d status results checked.", n_blocks, n_status);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
